// ===== rtl/assert_macros.svh =====
// Assertion macros included by typed_list_frame_deframer to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tlfd_pkg.sv =====
// Types, codes and the fixed element size table of the typed list frame deframer.
package tlfd_pkg;

  localparam logic [2:0] PH_FRAME_HI = 3'd0;
  localparam logic [2:0] PH_FRAME_LO = 3'd1;
  localparam logic [2:0] PH_LIST_HI  = 3'd2;
  localparam logic [2:0] PH_LIST_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD  = 3'd4;
  localparam logic [2:0] PH_ERROR    = 3'd5;

  localparam logic [1:0] ROLE_FRAME_HDR = 2'd0;
  localparam logic [1:0] ROLE_LIST_HDR  = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD   = 2'd2;
  localparam logic [1:0] ROLE_DISCARD   = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ERR_BAD_TYPE  = 2'd2;

  localparam logic [11:0] FRAME_MAGIC = 12'hAAA;

  localparam logic [5:0] MAX_TYPE      = 6'd20;
  localparam logic [5:0] TYPE_PLAYER   = 6'd7;
  localparam logic [5:0] TYPE_COIN     = 6'd9;
  localparam logic [5:0] TYPE_OBSTACLE = 6'd10;
  localparam logic [5:0] TYPE_START    = 6'd14;
  localparam logic [5:0] TYPE_END      = 6'd20;

  localparam logic [1:0] CFG_PLAYER   = 2'd0;
  localparam logic [1:0] CFG_COIN     = 2'd1;
  localparam logic [1:0] CFG_OBSTACLE = 2'd2;

  localparam logic [7:0] PLAYER_RESET   = 8'd24;
  localparam logic [7:0] COIN_RESET     = 8'd16;
  localparam logic [7:0] OBSTACLE_RESET = 8'd24;

  typedef struct packed {
    logic [7:0] player;
    logic [7:0] coin;
    logic [7:0] obstacle;
  } tlfd_cfg_t;

  typedef struct packed {
    logic       end_seen;
    logic       start_seen;
    logic [1:0] error_code;
    logic       frame_last;
    logic       list_last;
    logic       element_last;
    logic [9:0] element_index;
    logic [5:0] list_type;
    logic [1:0] byte_role;
    logic [7:0] byte_value;
  } tlfd_result_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] error;
  } tlfd_status_t;

  // Fixed bytes per element; configurable and unknown types give zero here.
  function automatic logic [7:0] fixed_size(input logic [5:0] type_code);
    logic [7:0] sz;
    case (type_code)
      6'd1:    sz = 8'd4;
      6'd2:    sz = 8'd8;
      6'd3:    sz = 8'd1;
      6'd4:    sz = 8'd8;
      6'd5:    sz = 8'd4;
      6'd6:    sz = 8'd2;
      6'd8:    sz = 8'd20;
      6'd12:   sz = 8'd4;
      6'd13:   sz = 8'd1;
      6'd16:   sz = 8'd4;
      6'd17:   sz = 8'd8;
      6'd19:   sz = 8'd4;
      default: sz = 8'd0;
    endcase
    return sz;
  endfunction

endpackage

// ===== rtl/tlfd_size_lut.sv =====
// Element size lookup: fixed table plus the three configurable record sizes.
module tlfd_size_lut import tlfd_pkg::*; (
  input  tlfd_cfg_t  cfg,
  input  logic [5:0] type_code,
  output logic [7:0] elem_size
);

  always_comb begin
    case (type_code)
      TYPE_PLAYER:   elem_size = cfg.player;
      TYPE_COIN:     elem_size = cfg.coin;
      TYPE_OBSTACLE: elem_size = cfg.obstacle;
      default:       elem_size = fixed_size(type_code);
    endcase
  end

endmodule

// ===== rtl/tlfd_parser.sv =====
// Frame parser: parse state registers and the per-byte tagging logic.
module tlfd_parser import tlfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_fire,
  input  logic [7:0]   in_byte,
  input  tlfd_cfg_t    cfg,
  output tlfd_result_t res,
  output tlfd_status_t status
);

  logic [2:0] phase_r, phase_nxt;
  logic [3:0] lists_left_r, lists_left_nxt;
  logic [7:0] held_r, held_nxt;
  logic [5:0] cur_type_r, cur_type_nxt;
  logic [9:0] elems_left_r, elems_left_nxt;
  logic [9:0] elem_cnt_r, elem_cnt_nxt;
  logic [7:0] bie_r, bie_nxt;
  logic [1:0] err_r, err_nxt;
  logic       start_r, start_nxt;
  logic       end_r, end_nxt;

  logic [7:0] size_new, size_cur;
  logic [9:0] list_cnt;
  logic [5:0] hdr_type;
  logic [8:0] pos;
  logic [9:0] elems_dec;
  logic [3:0] lists_dec;

  assign list_cnt  = {held_r, in_byte[7:6]};
  assign hdr_type  = in_byte[5:0];
  assign pos       = {1'b0, bie_r} + 9'd1;
  assign elems_dec = elems_left_r - 10'd1;
  assign lists_dec = lists_left_r - 4'd1;

  tlfd_size_lut u_size_new (.cfg(cfg), .type_code(hdr_type),   .elem_size(size_new));
  tlfd_size_lut u_size_cur (.cfg(cfg), .type_code(cur_type_r), .elem_size(size_cur));

  always_comb begin
    phase_nxt      = phase_r;
    lists_left_nxt = lists_left_r;
    held_nxt       = held_r;
    cur_type_nxt   = cur_type_r;
    elems_left_nxt = elems_left_r;
    elem_cnt_nxt   = elem_cnt_r;
    bie_nxt        = bie_r;
    err_nxt        = err_r;
    start_nxt      = start_r;
    end_nxt        = end_r;

    res               = '0;
    res.byte_value    = in_byte;
    res.byte_role     = ROLE_DISCARD;

    unique case (phase_r)
      PH_FRAME_HI: begin
        res.byte_role = ROLE_FRAME_HDR;
        held_nxt      = in_byte;
        phase_nxt     = PH_FRAME_LO;
      end
      PH_FRAME_LO: begin
        res.byte_role = ROLE_FRAME_HDR;
        if ({held_r, in_byte[7:4]} != FRAME_MAGIC) begin
          err_nxt   = ERR_BAD_MAGIC;
          phase_nxt = PH_ERROR;
        end else begin
          lists_left_nxt = in_byte[3:0];
          if (in_byte[3:0] == 4'd0) begin
            res.frame_last = 1'b1;
            phase_nxt      = PH_FRAME_HI;
          end else begin
            phase_nxt = PH_LIST_HI;
          end
        end
      end
      PH_LIST_HI: begin
        res.byte_role = ROLE_LIST_HDR;
        held_nxt      = in_byte;
        phase_nxt     = PH_LIST_LO;
      end
      PH_LIST_LO: begin
        res.byte_role = ROLE_LIST_HDR;
        res.list_type = hdr_type;
        if (hdr_type > MAX_TYPE) begin
          err_nxt   = ERR_BAD_TYPE;
          phase_nxt = PH_ERROR;
        end else begin
          cur_type_nxt = hdr_type;
          if (list_cnt != 10'd0) begin
            if (hdr_type == TYPE_START) start_nxt = 1'b1;
            if (hdr_type == TYPE_END)   end_nxt   = 1'b1;
          end
          if (list_cnt == 10'd0 || size_new == 8'd0) begin
            // an empty list or a list of zero-size elements completes on its own header
            res.list_last  = 1'b1;
            lists_left_nxt = lists_dec;
            if (lists_dec == 4'd0) begin
              res.frame_last = 1'b1;
              phase_nxt      = PH_FRAME_HI;
            end else begin
              phase_nxt = PH_LIST_HI;
            end
          end else begin
            elems_left_nxt = list_cnt;
            elem_cnt_nxt   = 10'd0;
            bie_nxt        = 8'd0;
            phase_nxt      = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res.byte_role     = ROLE_PAYLOAD;
        res.list_type     = cur_type_r;
        res.element_index = elem_cnt_r;
        if (pos >= {1'b0, size_cur}) begin
          res.element_last = 1'b1;
          bie_nxt          = 8'd0;
          elem_cnt_nxt     = elem_cnt_r + 10'd1;
          elems_left_nxt   = elems_dec;
          if (elems_dec == 10'd0) begin
            res.list_last  = 1'b1;
            lists_left_nxt = lists_dec;
            if (lists_dec == 4'd0) begin
              res.frame_last = 1'b1;
              phase_nxt      = PH_FRAME_HI;
            end else begin
              phase_nxt = PH_LIST_HI;
            end
          end
        end else begin
          bie_nxt = pos[7:0];
        end
      end
      PH_ERROR: begin
        phase_nxt = PH_ERROR;
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase

    res.error_code = err_nxt;
    res.start_seen = start_nxt;
    res.end_seen   = end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FRAME_HI;
      lists_left_r <= 4'd0;
      held_r       <= 8'd0;
      cur_type_r   <= 6'd0;
      elems_left_r <= 10'd0;
      elem_cnt_r   <= 10'd0;
      bie_r        <= 8'd0;
      err_r        <= ERR_NONE;
      start_r      <= 1'b0;
      end_r        <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      lists_left_r <= lists_left_nxt;
      held_r       <= held_nxt;
      cur_type_r   <= cur_type_nxt;
      elems_left_r <= elems_left_nxt;
      elem_cnt_r   <= elem_cnt_nxt;
      bie_r        <= bie_nxt;
      err_r        <= err_nxt;
      start_r      <= start_nxt;
      end_r        <= end_nxt;
    end
  end

  assign status.phase = phase_r;
  assign status.error = err_r;

endmodule

// ===== rtl/tlfd_out_buf.sv =====
// Result register with a skid slot, so a stalled receiver does not stop intake at once.
module tlfd_out_buf import tlfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  tlfd_result_t push_data,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output tlfd_result_t out_data
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  tlfd_result_t main_r, main_nxt;
  tlfd_result_t skid_r, skid_nxt;
  logic         pop;

  assign pop      = main_valid_r & out_ready;
  assign can_push = ~skid_valid_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ===== rtl/typed_list_frame_deframer.sv =====
// Top level of the typed list frame deframer: config registers, parser and result buffer.
//
// Usage:
//   in_*  : one received byte per transfer in in_tdata[7:0].
//   out_* : one tagged result per input byte. out_tuser carries the byte role,
//           out_tlast marks the byte that completes a frame.
//   cfg_* : register write channel, always ready; index 0 player record size,
//           1 coin record size, 2 obstacle record size, index 3 is ignored.
//           Write only while no result is pending.
// Result: each byte's tag lands in the output register, or in the skid slot while
//   that holds an untaken result. Throughput: one byte per cycle while in_tready
//   is high; the parse state is updated by one pass of short logic per byte.
// Stall: a two-entry result buffer (output register plus skid slot) keeps
//   in_tready high until both entries hold untaken results; then intake holds
//   until out_tready takes one.
// Reset (rst_n low, synchronous): drop buffered results, return to the frame
//   header, clear the error and the start and end flags, reload record sizes.
// A bad magic or a type above 20 sticks in the error state until reset; all
//   later bytes come out with the discarded role.
module typed_list_frame_deframer import tlfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [7:0] byte_value, [13:8] list_type, [23:14] element_index,
  //   [24] element_last, [25] list_last, [27:26] error_code, [28] start_seen,
  //   [29] end_seen, [31:30] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: [1:0] byte_role
  output logic [1:0]  out_tuser,
  // out_tlast: frame_last
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

`include "assert_macros.svh"

  tlfd_cfg_t    cfg_r, cfg_nxt;
  tlfd_result_t res, out_res;
  tlfd_status_t status;
  logic         in_fire;
  logic         can_push;

  // Config registers: always ready, unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PLAYER:   cfg_nxt.player   = cfg_data;
        CFG_COIN:     cfg_nxt.coin     = cfg_data;
        CFG_OBSTACLE: cfg_nxt.obstacle = cfg_data;
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.player   <= PLAYER_RESET;
      cfg_r.coin     <= COIN_RESET;
      cfg_r.obstacle <= OBSTACLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Advance the parser on every input transfer the buffer has room for.
  assign in_tready = can_push;
  assign in_fire   = in_tvalid & in_tready;

  tlfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .cfg     (cfg_r),
    .res     (res),
    .status  (status)
  );

  tlfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  // Pack the result fields onto the stream ports.
  assign out_tdata = {2'b00, out_res.end_seen, out_res.start_seen, out_res.error_code,
                      out_res.list_last, out_res.element_last, out_res.element_index,
                      out_res.list_type, out_res.byte_value};
  assign out_tuser = out_res.byte_role;
  assign out_tlast = out_res.frame_last;

  // A full buffer always presents a result.
  `ASSERT_IMPLIES(a_full_has_output, !in_tready, out_tvalid, "full buffer shows no result")
  // Every input transfer leaves a result to deliver.
  `ASSERT_NEXT(a_fire_gives_result, in_fire, out_tvalid, "input transfer left no result")
  // The error phase always carries a latched error code.
  `ASSERT_IMPLIES(a_error_phase_code, status.phase == PH_ERROR, status.error != ERR_NONE, "error phase without code")
  // A latched error never clears outside reset.
  `ASSERT_NEXT(a_error_sticky, status.error != ERR_NONE, $stable(status.error), "latched error changed")

endmodule

// ===== verif/tb_top.sv =====
// Testbench for typed_list_frame_deframer: byte stream stimulus, in-bench parser model, checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlfd_pkg::*;

  // Size of the random part, in bytes, and stall handling.
  localparam int unsigned RANDOM_BYTES = 1350;
  localparam int unsigned LONG_HOLD    = 50;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;  // index the block must ignore
  localparam logic [5:0]  TYPE_BYTE    = 6'd3;  // fixed one-byte element type

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  always #6 clk = ~clk;

  typed_list_frame_deframer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Bytes waiting to be offered, and tagged results waiting to be seen.
  logic [7:0]   byte_feed[$];
  tlfd_result_t expected_tags[$];

  int unsigned bytes_queued   = 0;
  int unsigned results_taken  = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned next_hold_at   = 250;
  int unsigned tx_wait        = 0;
  int unsigned rx_wait        = 0;
  bit          tx_idle_on     = 1'b1;
  bit          rx_idle_on     = 1'b1;

  // Parser model state and its copy of the record size registers.
  logic [2:0] prs_phase;
  logic [3:0] prs_lists;
  logic [7:0] prs_held;
  logic [5:0] prs_type;
  logic [9:0] prs_elems;
  logic [9:0] prs_elem_idx;
  logic [7:0] prs_elem_pos;
  logic [1:0] prs_err;
  logic       prs_start;
  logic       prs_end;
  logic [7:0] rec_player;
  logic [7:0] rec_coin;
  logic [7:0] rec_obstacle;

  // Bytes per element of a list type under the current register values.
  function automatic logic [7:0] element_bytes(input logic [5:0] t);
    if (t == TYPE_PLAYER) return rec_player;
    if (t == TYPE_COIN) return rec_coin;
    if (t == TYPE_OBSTACLE) return rec_obstacle;
    case (t)
      6'd1, 6'd5, 6'd12, 6'd16, 6'd19: return 8'd4;
      6'd2, 6'd4, 6'd17:               return 8'd8;
      6'd3, 6'd13:                     return 8'd1;
      6'd6:                            return 8'd2;
      6'd8:                            return 8'd20;
      default:                         return 8'd0;
    endcase
  endfunction

  // A list just closed; step to the next list header or back to the frame header.
  function automatic logic close_list();
    prs_lists = prs_lists - 4'd1;
    if (prs_lists == 4'd0) begin
      prs_phase = PH_FRAME_HI;
      return 1'b1;
    end
    prs_phase = PH_LIST_HI;
    return 1'b0;
  endfunction

  // Advance the parser model by one byte and return the tag it should carry.
  function automatic tlfd_result_t tag_byte(input logic [7:0] b);
    tlfd_result_t r;
    logic [15:0]  hdr;
    logic [5:0]   t;
    logic [8:0]   pos;
    r = '0;
    r.byte_value = b;
    r.byte_role = ROLE_DISCARD;
    hdr = {prs_held, b};
    t = b[5:0];
    case (prs_phase)
      PH_FRAME_HI: begin
        r.byte_role = ROLE_FRAME_HDR;
        prs_held = b;
        prs_phase = PH_FRAME_LO;
      end
      PH_FRAME_LO: begin
        r.byte_role = ROLE_FRAME_HDR;
        if (hdr[15:4] != FRAME_MAGIC) begin
          prs_err = ERR_BAD_MAGIC;
          prs_phase = PH_ERROR;
        end else begin
          prs_lists = b[3:0];
          if (prs_lists == 4'd0) begin
            r.frame_last = 1'b1;
            prs_phase = PH_FRAME_HI;
          end else begin
            prs_phase = PH_LIST_HI;
          end
        end
      end
      PH_LIST_HI: begin
        r.byte_role = ROLE_LIST_HDR;
        prs_held = b;
        prs_phase = PH_LIST_LO;
      end
      PH_LIST_LO: begin
        r.byte_role = ROLE_LIST_HDR;
        r.list_type = t;
        if (t > MAX_TYPE) begin
          prs_err = ERR_BAD_TYPE;
          prs_phase = PH_ERROR;
        end else begin
          prs_type = t;
          // Game events latch only when the list actually holds elements.
          if (hdr[15:6] != 10'd0) begin
            if (t == TYPE_START) prs_start = 1'b1;
            if (t == TYPE_END) prs_end = 1'b1;
          end
          if (hdr[15:6] == 10'd0 || element_bytes(t) == 8'd0) begin
            r.list_last = 1'b1;
            r.frame_last = close_list();
          end else begin
            prs_elems = hdr[15:6];
            prs_elem_idx = '0;
            prs_elem_pos = '0;
            prs_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        r.byte_role = ROLE_PAYLOAD;
        r.list_type = prs_type;
        r.element_index = prs_elem_idx;
        // Reaching or passing the size ends the element, so a shrunk size cuts it short.
        pos = {1'b0, prs_elem_pos} + 9'd1;
        if (pos >= {1'b0, element_bytes(prs_type)}) begin
          r.element_last = 1'b1;
          prs_elem_pos = '0;
          prs_elem_idx = prs_elem_idx + 10'd1;
          prs_elems = prs_elems - 10'd1;
          if (prs_elems == 10'd0) begin
            r.list_last = 1'b1;
            r.frame_last = close_list();
          end
        end else begin
          prs_elem_pos = pos[7:0];
        end
      end
      default: prs_phase = PH_ERROR;
    endcase
    r.error_code = prs_err;
    r.start_seen = prs_start;
    r.end_seen = prs_end;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < 40)
      $display("MISMATCH at result %0d: %s got %0d want %0d", results_taken, what, got, want);
    mismatch_count++;
  endtask

  // Driver: offer queued bytes, hold a byte until it transfers, predict on transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_wait = 0;
      prs_phase = PH_FRAME_HI;
      prs_lists = '0;
      prs_held = '0;
      prs_type = '0;
      prs_elems = '0;
      prs_elem_idx = '0;
      prs_elem_pos = '0;
      prs_err = ERR_NONE;
      prs_start = 1'b0;
      prs_end = 1'b0;
      rec_player = PLAYER_RESET;
      rec_coin = COIN_RESET;
      rec_obstacle = OBSTACLE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PLAYER:   rec_player = cfg_data;
          CFG_COIN:     rec_coin = cfg_data;
          CFG_OBSTACLE: rec_obstacle = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_tags.insert(expected_tags.size(), tag_byte(in_tdata));
        tx_wait = tx_idle_on ? $urandom_range(0, 4) : 0;
      end
      // Leave a byte that is still waiting for in_tready untouched.
      if (!(in_tvalid && !in_tready)) begin
        if (tx_wait > 0) begin
          in_tvalid <= 1'b0;
          tx_wait--;
        end else if (byte_feed.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_feed.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results, compare against the oldest prediction, stall at random.
  always @(posedge clk) begin : result_check
    tlfd_result_t got;
    tlfd_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.byte_value = out_tdata[7:0];
        got.list_type = out_tdata[13:8];
        got.element_index = out_tdata[23:14];
        got.element_last = out_tdata[24];
        got.list_last = out_tdata[25];
        got.error_code = out_tdata[27:26];
        got.start_seen = out_tdata[28];
        got.end_seen = out_tdata[29];
        got.byte_role = out_tuser;
        got.frame_last = out_tlast;
        if (expected_tags.size() == 0) begin
          report_mismatch("result with nothing pending, byte", got.byte_value, 0);
        end else begin
          want = expected_tags.pop_front();
          if (got.byte_value !== want.byte_value)
            report_mismatch("byte_value", got.byte_value, want.byte_value);
          if (got.byte_role !== want.byte_role)
            report_mismatch("byte_role", got.byte_role, want.byte_role);
          if (got.list_type !== want.list_type)
            report_mismatch("list_type", got.list_type, want.list_type);
          if (got.element_index !== want.element_index)
            report_mismatch("element_index", got.element_index, want.element_index);
          if (got.element_last !== want.element_last)
            report_mismatch("element_last", got.element_last, want.element_last);
          if (got.list_last !== want.list_last)
            report_mismatch("list_last", got.list_last, want.list_last);
          if (got.frame_last !== want.frame_last)
            report_mismatch("frame_last", got.frame_last, want.frame_last);
          if (got.error_code !== want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
          if (got.start_seen !== want.start_seen)
            report_mismatch("start_seen", got.start_seen, want.start_seen);
          if (got.end_seen !== want.end_seen)
            report_mismatch("end_seen", got.end_seen, want.end_seen);
          if (out_tdata[31:30] !== 2'b00)
            report_mismatch("tdata padding", out_tdata[31:30], 0);
        end
        results_taken++;
        rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
        // Hold off long while plenty of bytes are queued so the block fills and stalls.
        if (results_taken >= next_hold_at && byte_feed.size() >= 30) begin
          rx_wait = LONG_HOLD;
          next_hold_at = results_taken + 400;
        end
      end
      if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no channel transfers anything for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("typed_list_frame_deframer verification failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    byte_feed.insert(byte_feed.size(), b);
    bytes_queued++;
  endtask

  task automatic push_frame_hdr(input logic [3:0] n_lists);
    logic [15:0] hdr;
    hdr = {FRAME_MAGIC, n_lists};
    push_byte(hdr[15:8]);
    push_byte(hdr[7:0]);
  endtask

  task automatic push_list_hdr(input logic [9:0] cnt, input logic [5:0] t);
    logic [15:0] hdr;
    hdr = {cnt, t};
    push_byte(hdr[15:8]);
    push_byte(hdr[7:0]);
  endtask

  // Header plus a whole payload of random bytes at the current element size.
  task automatic push_list(input logic [9:0] cnt, input logic [5:0] t);
    int unsigned n;
    n = int'(cnt) * int'(element_bytes(t));
    push_list_hdr(cnt, t);
    repeat (n) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Well-formed frame: mostly a few lists, sometimes up to fifteen.
  task automatic push_random_frame();
    int unsigned n_lists;
    logic [5:0]  t;
    logic [9:0]  cnt;
    logic [7:0]  sz;
    n_lists = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    push_frame_hdr(4'(n_lists));
    repeat (n_lists) begin
      t = 6'($urandom_range(0, MAX_TYPE));
      sz = element_bytes(t);
      if (sz == 8'd0)
        cnt = 10'($urandom_range(0, 1023));
      else if (sz > 8'd24)
        cnt = 10'($urandom_range(0, 1));
      else
        cnt = ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 4));
      push_list(cnt, t);
    end
  endtask

  task automatic write_size_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Sender pause: let every queued byte transfer and every result arrive.
  task automatic wait_drained();
    @(negedge clk);
    while (byte_feed.size() != 0 || in_tvalid || expected_tags.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase_start;
    int unsigned phase_len;
    int unsigned phase_no;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [7:0]  val;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty frame, start list with and without elements, end list with
    // a full-width count, then a player element cut short by a smaller size.
    push_frame_hdr(4'd0);
    push_frame_hdr(4'd3);
    push_list(10'd0, TYPE_START);
    push_list(10'd1, TYPE_START);
    push_list(10'h3FF, TYPE_END);
    push_frame_hdr(4'd1);
    push_list_hdr(10'd2, TYPE_PLAYER);
    push_byte(8'h00);
    push_byte(8'hFF);
    repeat (3) push_byte(8'($urandom_range(0, 255)));
    wait_drained();
    // Shrink the player size mid-element; the next byte closes the element.
    write_size_reg(CFG_PLAYER, 8'd3);
    write_size_reg(CFG_COIN, 8'd0);
    write_size_reg(CFG_OBSTACLE, 8'd255);
    write_size_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
    @(negedge clk);
    repeat (4) push_byte(8'($urandom_range(0, 255)));
    // Coin elements of size zero: the list closes on its header.
    push_frame_hdr(4'd1);
    push_list(10'd3, TYPE_COIN);
    wait_drained();

    // Random part in phases that end on frame boundaries; registers change between them.
    random_start = bytes_queued;
    phase_no = 0;
    while (bytes_queued - random_start < RANDOM_BYTES) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(60, 200);
      phase_start = bytes_queued;
      if (phase_no == 1) begin
        // One long list of byte elements walks the element index through every bit.
        push_frame_hdr(4'd1);
        push_list(10'h3FF, TYPE_BYTE);
      end
      while (bytes_queued - phase_start < phase_len) push_random_frame();
      wait_drained();
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0:       val = 8'd0;
          1:       val = 8'd1;
          2:       val = 8'd255;
          default: val = 8'($urandom_range(0, 255));
        endcase
        write_size_reg(2'($urandom_range(0, 3)), val);
      end
      @(negedge clk);
      phase_no++;
    end

    // The error state sticks until reset, so one error closes the run.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    if ($urandom_range(0, 1) == 0) begin
      hi = 8'($urandom_range(0, 255));
      lo = 8'($urandom_range(0, 255));
      if ({hi, lo[7:4]} == FRAME_MAGIC) lo[7:4] = ~lo[7:4];
      push_byte(hi);
      push_byte(lo);
    end else begin
      push_frame_hdr(4'($urandom_range(1, 15)));
      push_list_hdr(10'($urandom_range(0, 1023)), 6'($urandom_range(MAX_TYPE + 1, 63)));
    end
    repeat (40) push_byte(8'($urandom_range(0, 255)));
    wait_drained();

    repeat (4) @(posedge clk);
    if (expected_tags.size() != 0)
      report_mismatch("results outstanding", 0, expected_tags.size());
    if (mismatch_count == 0)
      $display("typed_list_frame_deframer verification clean");
    else
      $display("typed_list_frame_deframer verification failed");
    $finish;
  end

endmodule
